>>> rtl/lrc_pkg.sv
`default_nettype none

package lrc_pkg;

	localparam int COORD_W    = 25;
	localparam int MASK_W     = 32;
	localparam int CNT_W      = 6;
	localparam int SLOT_W     = 5;
	localparam int RAD_W      = 24;
	localparam int NORM_SHIFT = 14;
	localparam int BT_W       = 28;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int D_W        = 54;

	// Terrain patch extent: 512 units in Q16.8.
	localparam logic signed [BT_W-1:0] PATCH_EXTENT = 28'sd131072;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_PLANE   = 2'd1,
		OP_BOX     = 2'd2,
		OP_TERRAIN = 2'd3
	} lrc_op_t;

	typedef logic signed [COORD_W-1:0] lrc_coord_t;

	typedef struct packed {
		lrc_coord_t x;
		lrc_coord_t y;
		lrc_coord_t z;
	} lrc_vec3_t;

	typedef struct packed {
		lrc_op_t           op;
		logic [MASK_W-1:0] mask;
		logic [CNT_W-1:0]  count;
		logic [SLOT_W-1:0] slot;
		logic              wr_en;
		lrc_vec3_t         a;
		lrc_vec3_t         b;
		lrc_coord_t        w;
	} lrc_cmd_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              any;
	} lrc_res_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ISSUE = 2'd1,
		ST_DRAIN = 2'd2,
		ST_DONE  = 2'd3
	} lrc_state_t;

endpackage

`default_nettype wire

>>> rtl/lrc_fifo.sv
`default_nettype none

module lrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lrc_front.sv
`default_nettype none

module lrc_front
	import lrc_pkg::*;
#(
	parameter int MAX_LIGHTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        op,
	input  wire logic [MASK_W-1:0] mask_in,
	input  wire logic [SLOT_W-1:0] light_slot,
	input  wire lrc_vec3_t         vec_a,
	input  wire lrc_vec3_t         vec_b,
	input  wire lrc_coord_t        scalar_w,
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_wdata,
	output logic                   cmd_push,
	output lrc_cmd_t               cmd,
	input  wire logic              cmd_full
);

	logic [CNT_W-1:0]  light_count_q;
	logic [CNT_W-1:0]  eff_count;
	logic [MASK_W:0]   low_mask;
	lrc_op_t           op_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_count_q <= '0;
		end else if (cfg_we) begin
			light_count_q <= cfg_wdata;
		end
	end

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;
	assign op_dec   = lrc_op_t'(op);

	always_comb begin
		eff_count = (light_count_q > CNT_W'(MAX_LIGHTS)) ? CNT_W'(MAX_LIGHTS) : light_count_q;
		low_mask  = ((MASK_W+1)'(1) << eff_count) - (MASK_W+1)'(1);

		cmd.op    = op_dec;
		cmd.mask  = mask_in & low_mask[MASK_W-1:0];
		cmd.count = eff_count;
		cmd.slot  = light_slot;
		cmd.wr_en = (op_dec == OP_LOAD) && ({1'b0, light_slot} < CNT_W'(MAX_LIGHTS));
		cmd.a     = vec_a;
		cmd.b     = vec_b;
		// A load stores a negative radius as zero.
		cmd.w     = ((op_dec == OP_LOAD) && scalar_w[COORD_W-1]) ? '0 : scalar_w;
	end

endmodule

`default_nettype wire

>>> rtl/lrc_back.sv
`default_nettype none

module lrc_back
	import lrc_pkg::*;
#(
	parameter int MAX_LIGHTS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	input  wire lrc_cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	output lrc_res_t      res,
	input  wire logic     res_ready
);

	localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

	function automatic logic box_axis(
		input logic signed [BT_W-1:0] p,
		input logic signed [BT_W-1:0] r,
		input logic signed [BT_W-1:0] lo,
		input logic signed [BT_W-1:0] hi
	);
		return ((p - r) > hi) || ((p + r) < lo);
	endfunction

	function automatic logic patch_axis(
		input logic signed [BT_W-1:0] c,
		input logic signed [BT_W-1:0] p,
		input logic signed [BT_W-1:0] r,
		input logic signed [BT_W-1:0] lim
	);
		logic signed [BT_W-1:0] d;
		d = c - p;
		return (d > r) || (d < (lim - r));
	endfunction

	// Light table.
	lrc_coord_t       mem_x [MAX_LIGHTS];
	lrc_coord_t       mem_y [MAX_LIGHTS];
	lrc_coord_t       mem_z [MAX_LIGHTS];
	logic [RAD_W-1:0] mem_r [MAX_LIGHTS];

	lrc_state_t        state_q, state_d;
	lrc_op_t           op_q;
	logic [MASK_W-1:0] mask_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	lrc_vec3_t         a_q;
	lrc_vec3_t         b_q;
	lrc_coord_t        w_q;
	logic              issue;

	// Stage 1: table read.
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	lrc_coord_t       rd_x_s1, rd_y_s1, rd_z_s1;
	logic [RAD_W-1:0] rd_r_s1;

	// Stage 2: products and the box or terrain verdict.
	logic                     v_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic [RAD_W-1:0]         r_s2;
	logic                     cull_bt_s2;

	// Stage 3: partial sums, final compare feeds the mask.
	logic                  v_s3;
	logic [IDX_W-1:0]      idx_s3;
	logic signed [D_W-1:0] sum_a_s3, sum_b_s3, r14_s3;
	logic                  cull_bt_s3;

	logic                  cull_bt;
	logic signed [D_W-1:0] plane_d;
	logic                  plane_cull;
	logic                  cull;

	// Control FSM.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ((cmd.op == OP_LOAD) || (cmd.count == '0)) ? ST_DONE : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (idx_q == (count_q - CNT_W'(1))) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		issue     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE:  cmd_pop   = cmd_valid;
			ST_ISSUE: issue     = 1'b1;
			ST_DONE:  res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res.mask = mask_q;
	assign res.any  = |mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q    <= cmd.op;
			mask_q  <= (cmd.op == OP_LOAD) ? '0 : cmd.mask;
			count_q <= cmd.count;
			idx_q   <= '0;
			a_q     <= cmd.a;
			b_q     <= cmd.b;
			w_q     <= cmd.w;
		end else begin
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (v_s3 && cull) begin
				mask_q <= mask_q & ~(MASK_W'(1) << idx_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.wr_en) begin
			mem_x[cmd.slot[IDX_W-1:0]] <= cmd.a.x;
			mem_y[cmd.slot[IDX_W-1:0]] <= cmd.a.y;
			mem_z[cmd.slot[IDX_W-1:0]] <= cmd.a.z;
			mem_r[cmd.slot[IDX_W-1:0]] <= cmd.w[RAD_W-1:0];
		end
		rd_x_s1 <= mem_x[idx_q[IDX_W-1:0]];
		rd_y_s1 <= mem_y[idx_q[IDX_W-1:0]];
		rd_z_s1 <= mem_z[idx_q[IDX_W-1:0]];
		rd_r_s1 <= mem_r[idx_q[IDX_W-1:0]];
		idx_s1  <= idx_q[IDX_W-1:0];
	end

	always_comb begin
		logic signed [BT_W-1:0] px, py, pz, r;
		logic                   box_c, patch_c;
		px      = BT_W'(rd_x_s1);
		py      = BT_W'(rd_y_s1);
		pz      = BT_W'(rd_z_s1);
		r       = $signed({{(BT_W-RAD_W){1'b0}}, rd_r_s1});
		box_c   = box_axis(px, r, BT_W'(a_q.x), BT_W'(b_q.x))
		       || box_axis(py, r, BT_W'(a_q.y), BT_W'(b_q.y))
		       || box_axis(pz, r, BT_W'(a_q.z), BT_W'(b_q.z));
		patch_c = patch_axis(BT_W'(a_q.x), px, r, -PATCH_EXTENT)
		       || patch_axis(BT_W'(a_q.y), py, r, -PATCH_EXTENT)
		       || patch_axis(BT_W'(a_q.z), pz, r, -BT_W'(b_q.z));
		cull_bt = (op_q == OP_BOX) ? box_c : patch_c;
	end

	always_ff @(posedge clk) begin
		idx_s2     <= idx_s1;
		prod_x_s2  <= rd_x_s1 * a_q.x;
		prod_y_s2  <= rd_y_s1 * a_q.y;
		prod_z_s2  <= rd_z_s1 * a_q.z;
		r_s2       <= rd_r_s1;
		cull_bt_s2 <= cull_bt;

		idx_s3     <= idx_s2;
		sum_a_s3   <= D_W'(prod_x_s2) + D_W'(prod_y_s2);
		sum_b_s3   <= D_W'(prod_z_s2) - (D_W'(w_q) <<< NORM_SHIFT);
		r14_s3     <= $signed({{(D_W-RAD_W-NORM_SHIFT){1'b0}}, r_s2, {NORM_SHIFT{1'b0}}});
		cull_bt_s3 <= cull_bt_s2;
	end

	always_comb begin
		plane_d    = sum_a_s3 + sum_b_s3;
		plane_cull = (plane_d < -r14_s3) || (plane_d > r14_s3);
		cull       = (op_q == OP_PLANE) ? plane_cull : cull_bt_s3;
	end

endmodule

`default_nettype wire

>>> rtl/light_reach_culling_unit.sv
// A load beat writes one table entry; a query with N active lights takes the beat, reads
// the N table entries in turn, drains the test pipeline and hands its result over.
// A query with no active lights skips the table reads. The back end takes the next beat
// only once the result of the last one has been handed to the result queue.
// Reset: arst_n clears the queues, light_count and the sequencer at once; the light
// table is not cleared and holds whatever it held until a load writes an entry.
`default_nettype none

module light_reach_culling_unit
	import lrc_pkg::*;
#(
	parameter int MAX_LIGHTS = 32,
	parameter int CMD_DEPTH  = 4,
	parameter int RES_DEPTH  = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	// Item side: a beat is taken when push is high and full is low.
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        op,
	input  wire logic [MASK_W-1:0] mask_in,
	input  wire logic [SLOT_W-1:0] light_slot,
	input  wire lrc_coord_t        vec_a_x,
	input  wire lrc_coord_t        vec_a_y,
	input  wire lrc_coord_t        vec_a_z,
	input  wire lrc_coord_t        vec_b_x,
	input  wire lrc_coord_t        vec_b_y,
	input  wire lrc_coord_t        vec_b_z,
	input  wire lrc_coord_t        scalar_w,

	// light_count register.
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_wdata,

	// Result side: the oldest result is shown while empty is low.
	output logic                   empty,
	input  wire logic              pop,
	output logic [MASK_W-1:0]      mask_out,
	output logic                   any_light
);

	// The front end decodes each beat, clamps the light count, trims the mask to the
	// active lights and clamps a load's radius. It drops the result into a small
	// command queue so that it keeps taking beats while the back end is busy.
	lrc_cmd_t  cmd_wr, cmd_rd;
	logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
	lrc_vec3_t vec_a, vec_b;

	// The back end owns the light table. A load writes one entry; a query walks the
	// active lights through a three-stage test pipeline and clears the mask bits of
	// lights that cannot reach the surface.
	lrc_res_t  res_wr, res_rd;
	logic      res_valid, res_full, res_push;

	assign vec_a = '{x: vec_a_x, y: vec_a_y, z: vec_a_z};
	assign vec_b = '{x: vec_b_x, y: vec_b_y, z: vec_b_z};

	lrc_front #(
		.MAX_LIGHTS(MAX_LIGHTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.mask_in   (mask_in),
		.light_slot(light_slot),
		.vec_a     (vec_a),
		.vec_b     (vec_b),
		.scalar_w  (scalar_w),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_push  (cmd_push),
		.cmd       (cmd_wr),
		.cmd_full  (cmd_full)
	);

	lrc_fifo #(
		.WIDTH($bits(lrc_cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_wr),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rd),
		.empty  (cmd_empty)
	);

	lrc_back #(
		.MAX_LIGHTS(MAX_LIGHTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!cmd_empty),
		.cmd      (cmd_rd),
		.cmd_pop  (cmd_pop),
		.res_valid(res_valid),
		.res      (res_wr),
		.res_ready(!res_full)
	);

	// The result queue parts the back end from the consumer, so a stalled pop does not
	// hold up the light walk of the next query until the result queue is full.
	assign res_push = res_valid && !res_full;

	lrc_fifo #(
		.WIDTH($bits(lrc_res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_wr),
		.full   (res_full),
		.rd_en  (pop && !empty),
		.rd_data(res_rd),
		.empty  (empty)
	);

	assign mask_out  = res_rd.mask;
	assign any_light = res_rd.any;

endmodule

`default_nettype wire

>>> rtl/lrc_checker.sv
`default_nettype none

module lrc_checker
	import lrc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_we,
	input wire logic [CNT_W-1:0]  cfg_wdata,
	input wire logic              empty,
	input wire logic              pop,
	input wire logic [MASK_W-1:0] mask_out,
	input wire logic              any_light
);

	logic [CNT_W-1:0] count_q;
	logic [MASK_W:0]  low_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	assign low_mask = ((MASK_W+1)'(1) << count_q) - (MASK_W+1)'(1);

	// The flag must agree with the mask it travels with.
	a_any_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (any_light == (mask_out != '0)))
		else $error("any_light disagrees with mask_out");

	// No light at or above the programmed count survives.
	a_mask_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((mask_out & ~low_mask[MASK_W-1:0]) == '0))
		else $error("mask_out has a bit beyond light_count");

	// A waiting result stays put until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(mask_out) && $stable(any_light)))
		else $error("result changed while waiting");

endmodule

bind light_reach_culling_unit lrc_checker u_lrc_checker (.*);

`default_nettype wire
